// ===== hw/rtl/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and constants of the shell line tokenizer: token kinds,
// lexer modes, result records and output queue sizing.
// ----------------------------------------------------------------------------
package slt_pkg;

  // longest word that the word counter tracks before it saturates
  localparam int unsigned WordMax = 1023;
  localparam int unsigned CountW  = $clog2(WordMax + 1);

  // widths of the result fields
  localparam int unsigned KindW = 4;
  localparam int unsigned DataW = 8;
  localparam int unsigned LenW  = 10;
  localparam logic [LenW-1:0] LenMax = '1;

  // most results one request can cause
  localparam int unsigned MaxResults = 3;
  localparam int unsigned NumW       = $clog2(MaxResults + 1);

  // output queue
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // special bytes
  localparam logic [DataW-1:0] ChBackslash = 8'd92;
  localparam logic [DataW-1:0] ChDquote    = 8'd34;
  localparam logic [DataW-1:0] ChSquote    = 8'd39;
  localparam logic [DataW-1:0] ChSpace     = 8'd32;
  localparam logic [DataW-1:0] ChLess      = 8'd60;
  localparam logic [DataW-1:0] ChGreater   = 8'd62;
  localparam logic [DataW-1:0] ChPipe      = 8'd124;

  typedef enum logic [KindW-1:0] {
    KindChar    = 4'd0,
    KindWordEnd = 4'd1,
    KindLt      = 4'd2,
    KindLtLt    = 4'd3,
    KindGt      = 4'd4,
    KindGtGt    = 4'd5,
    KindPipe    = 4'd6,
    KindEnd     = 4'd7,
    KindQuoteErr = 4'd8
  } kind_e;

  typedef enum logic [2:0] {
    ModePlain = 3'd0,
    ModeSq    = 3'd1,
    ModeDq    = 3'd2,
    ModeEsc   = 3'd3,
    ModeDqEsc = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    OpNone = 2'd0,
    OpLt   = 2'd1,
    OpGt   = 2'd2
  } op_e;

  typedef struct packed {
    kind_e            kind;
    logic [DataW-1:0] data;
    logic [LenW-1:0]  word_length;
    logic             last;
  } result_t;

  // results of one request, handed to the output queue
  typedef struct packed {
    logic [NumW-1:0]             num;
    result_t [MaxResults-1:0]    res;
  } lex_push_t;

  function automatic result_t mk_result(kind_e kind, logic [DataW-1:0] data,
                                        logic [LenW-1:0] len);
    result_t r;
    r.kind        = kind;
    r.data        = data;
    r.word_length = len;
    r.last        = 1'b0;
    return r;
  endfunction

  // saturate the word counter to the width of the length field
  function automatic logic [LenW-1:0] sat_len(logic [CountW-1:0] cnt);
    logic [31:0] wide;
    wide = 32'(cnt);
    return (wide > 32'(LenMax)) ? LenMax : wide[LenW-1:0];
  endfunction

endpackage

// ===== hw/rtl/slt_lexer.sv =====
// ----------------------------------------------------------------------------
// slt_lexer
// Input register and lexer state. Each registered request is decoded in one
// pass into up to three results, pushed into the output queue together.
// ----------------------------------------------------------------------------
module slt_lexer (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     command_i,
  input  logic [slt_pkg::DataW-1:0] byte_req_i,
  input  logic                     space_i,
  output slt_pkg::lex_push_t       push_o
);

  logic                      valid_q;
  logic                      cmd_q;
  logic [slt_pkg::DataW-1:0] byte_q;
  logic                      go;

  slt_pkg::mode_e             mode_q, mode_d;
  slt_pkg::op_e               op_q, op_d;
  logic [slt_pkg::CountW-1:0] cnt_q, cnt_d;

  assign go         = valid_q & space_i;
  assign in_stall_o = valid_q & ~space_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      cmd_q  <= command_i;
      byte_q <= byte_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= slt_pkg::ModePlain;
      op_q   <= slt_pkg::OpNone;
      cnt_q  <= '0;
    end else if (go) begin
      mode_q <= mode_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_comb begin
    slt_pkg::result_t [slt_pkg::MaxResults-1:0] res;
    logic [slt_pkg::NumW-1:0] n;
    logic                     done;

    res    = '0;
    n      = '0;
    done   = 1'b0;
    mode_d = mode_q;
    op_d   = op_q;
    cnt_d  = cnt_q;

    if (cmd_q) begin
      // end of line: flush a waiting single operator first
      if (op_q == slt_pkg::OpLt) begin
        res[n] = slt_pkg::mk_result(slt_pkg::KindLt, '0, '0);
        n = n + 1'b1;
      end else if (op_q == slt_pkg::OpGt) begin
        res[n] = slt_pkg::mk_result(slt_pkg::KindGt, '0, '0);
        n = n + 1'b1;
      end
      if (mode_q == slt_pkg::ModeSq || mode_q == slt_pkg::ModeDq ||
          mode_q == slt_pkg::ModeDqEsc) begin
        res[n] = slt_pkg::mk_result(slt_pkg::KindQuoteErr, '0, '0);
        n = n + 1'b1;
      end else begin
        // trailing backslash outside quotes is a literal character
        if (mode_q == slt_pkg::ModeEsc) begin
          res[n] = slt_pkg::mk_result(slt_pkg::KindChar, slt_pkg::ChBackslash, '0);
          n = n + 1'b1;
          if (32'(cnt_d) < slt_pkg::WordMax) begin
            cnt_d = cnt_d + 1'b1;
          end
        end
        if (cnt_d != '0) begin
          res[n] = slt_pkg::mk_result(slt_pkg::KindWordEnd, '0, slt_pkg::sat_len(cnt_d));
          n = n + 1'b1;
        end
        res[n] = slt_pkg::mk_result(slt_pkg::KindEnd, '0, '0);
        n = n + 1'b1;
      end
      mode_d = slt_pkg::ModePlain;
      op_d   = slt_pkg::OpNone;
      cnt_d  = '0;
    end else begin
      if (op_q != slt_pkg::OpNone) begin
        if (op_q == slt_pkg::OpLt && byte_q == slt_pkg::ChLess) begin
          res[n] = slt_pkg::mk_result(slt_pkg::KindLtLt, '0, '0);
          n = n + 1'b1;
          done = 1'b1;
        end else if (op_q == slt_pkg::OpGt && byte_q == slt_pkg::ChGreater) begin
          res[n] = slt_pkg::mk_result(slt_pkg::KindGtGt, '0, '0);
          n = n + 1'b1;
          done = 1'b1;
        end else begin
          res[n] = slt_pkg::mk_result((op_q == slt_pkg::OpLt) ? slt_pkg::KindLt
                                                                : slt_pkg::KindGt,
                                      '0, '0);
          n = n + 1'b1;
        end
        op_d = slt_pkg::OpNone;
      end

      if (!done) begin
        case (mode_q)
          slt_pkg::ModeSq: begin
            if (byte_q == slt_pkg::ChSquote) begin
              mode_d = slt_pkg::ModePlain;
            end else begin
              res[n] = slt_pkg::mk_result(slt_pkg::KindChar, byte_q, '0);
              n = n + 1'b1;
              if (32'(cnt_d) < slt_pkg::WordMax) cnt_d = cnt_d + 1'b1;
            end
          end
          slt_pkg::ModeDq: begin
            if (byte_q == slt_pkg::ChDquote) begin
              mode_d = slt_pkg::ModePlain;
            end else if (byte_q == slt_pkg::ChBackslash) begin
              mode_d = slt_pkg::ModeDqEsc;
            end else begin
              res[n] = slt_pkg::mk_result(slt_pkg::KindChar, byte_q, '0);
              n = n + 1'b1;
              if (32'(cnt_d) < slt_pkg::WordMax) cnt_d = cnt_d + 1'b1;
            end
          end
          slt_pkg::ModeDqEsc, slt_pkg::ModeEsc: begin
            res[n] = slt_pkg::mk_result(slt_pkg::KindChar, byte_q, '0);
            n = n + 1'b1;
            if (32'(cnt_d) < slt_pkg::WordMax) cnt_d = cnt_d + 1'b1;
            mode_d = (mode_q == slt_pkg::ModeDqEsc) ? slt_pkg::ModeDq
                                                     : slt_pkg::ModePlain;
          end
          default: begin
            mode_d = slt_pkg::ModePlain;
            if (byte_q == slt_pkg::ChBackslash) begin
              mode_d = slt_pkg::ModeEsc;
            end else if (byte_q == slt_pkg::ChDquote) begin
              mode_d = slt_pkg::ModeDq;
            end else if (byte_q == slt_pkg::ChSquote) begin
              mode_d = slt_pkg::ModeSq;
            end else if (byte_q == slt_pkg::ChLess || byte_q == slt_pkg::ChGreater ||
                         byte_q == slt_pkg::ChPipe || byte_q == slt_pkg::ChSpace) begin
              // separators close the current word
              if (cnt_d != '0) begin
                res[n] = slt_pkg::mk_result(slt_pkg::KindWordEnd, '0,
                                            slt_pkg::sat_len(cnt_d));
                n = n + 1'b1;
                cnt_d = '0;
              end
              if (byte_q == slt_pkg::ChLess) begin
                op_d = slt_pkg::OpLt;
              end else if (byte_q == slt_pkg::ChGreater) begin
                op_d = slt_pkg::OpGt;
              end else if (byte_q == slt_pkg::ChPipe) begin
                res[n] = slt_pkg::mk_result(slt_pkg::KindPipe, '0, '0);
                n = n + 1'b1;
              end
            end else begin
              res[n] = slt_pkg::mk_result(slt_pkg::KindChar, byte_q, '0);
              n = n + 1'b1;
              if (32'(cnt_d) < slt_pkg::WordMax) cnt_d = cnt_d + 1'b1;
            end
          end
        endcase
      end
    end

    // mark the final result of this request
    if (n != '0) begin
      res[n - 1'b1].last = 1'b1;
    end

    push_o.num = go ? n : '0;
    push_o.res = res;
  end

endmodule

// ===== hw/rtl/slt_queue.sv =====
// ----------------------------------------------------------------------------
// slt_queue
// Small output queue: takes up to three results in one cycle and hands out
// one result per cycle when not stalled. Reports room for a full request.
// ----------------------------------------------------------------------------
module slt_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  slt_pkg::lex_push_t         push_i,
  output logic                       space_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output slt_pkg::result_t           head_o
);

  slt_pkg::result_t [slt_pkg::QueueDepth-1:0] mem_q;
  logic [slt_pkg::QPtrW-1:0] wr_q, rd_q;
  logic [slt_pkg::QCntW-1:0] cnt_q;
  logic                      pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o & ~out_stall_i;
  assign head_o      = mem_q[rd_q];
  assign space_o     = (32'(cnt_q) + slt_pkg::MaxResults <= slt_pkg::QueueDepth);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + slt_pkg::QPtrW'(push_i.num);
      rd_q  <= rd_q + slt_pkg::QPtrW'(pop);
      cnt_q <= cnt_q + slt_pkg::QCntW'(push_i.num) - slt_pkg::QCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < slt_pkg::MaxResults; i++) begin
      if (32'(push_i.num) > i) begin
        mem_q[wr_q + slt_pkg::QPtrW'(i)] <= push_i.res[i];
      end
    end
  end

endmodule

// ===== hw/rtl/shell_line_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// shell_line_tokenizer_unit
// Splits a command line, one byte per request, into shell tokens: word
// characters, word ends, redirection operators, pipes, end of command.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                fields
//   input    in         in_valid_i / in_stall_o  command_i, byte_req_i
//   output   out        out_valid_o / out_stall_i kind_o, data_o,
//                                                word_length_o, last_o
//
// a request is registered, then decoded combinationally into up to three results
// that enter a four-entry output queue together; one request per cycle is
// taken while the queue has room for three results, one result leaves per
// cycle when not stalled, so single-result requests stream at full rate
// reset clears the lexer mode, pending operator, word counter and queue
// a stalled output only holds the input once the queue lacks that room
module shell_line_tokenizer_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      command_i,
  input  logic [slt_pkg::DataW-1:0] byte_req_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [slt_pkg::KindW-1:0] kind_o,
  output logic [slt_pkg::DataW-1:0] data_o,
  output logic [slt_pkg::LenW-1:0]  word_length_o,
  output logic                      last_o
);

  slt_pkg::lex_push_t push;
  slt_pkg::result_t   head;
  logic               space;

  slt_lexer u_lexer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .byte_req_i (byte_req_i),
    .space_i    (space),
    .push_o     (push)
  );

  slt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign kind_o        = head.kind;
  assign data_o        = head.data;
  assign word_length_o = head.word_length;
  assign last_o        = head.last;

endmodule
